// ===== src/b64enc_pkg.sv =====
// ============================================================================
// b64enc_pkg
// Shared types and constants for the base64 stream encoder.
// ============================================================================
package b64enc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 24;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned FILL_W  = 2;

   localparam logic [BYTE_W-1:0]  PAD_CHAR  = 8'h3D;
   localparam logic [FILL_W-1:0]  FILL_NONE = 2'd0;
   localparam logic [FILL_W-1:0]  FILL_ONE  = 2'd1;
   localparam logic [FILL_W-1:0]  FILL_TWO  = 2'd2;

   // One closed group: 24-bit word, number of data chars (2..4), message end.
   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] data_count;
      logic               last;
   } group_type;

   function automatic logic [BYTE_W-1:0] sextet_char(input logic [5:0] v);
      logic [BYTE_W-1:0] c;
      c = '0;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage

// ===== src/base64_stream_encoder.sv =====
// ============================================================================
// base64_stream_encoder
// Base64 encoder: one byte per request, one character per response.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   req_push/req_full  req_data_byte[8], req_end_of_message
//  response  rsp_pop/rsp_empty  rsp_code_char[8], rsp_final_char
//
//  A request is taken while the group queue has room.
//  The back part emits one character per cycle while the consumer pops;
//  each group of three bytes gives four characters.
//  A closed group goes through the group queue, then the back part's group register.
//  Synchronous reset clears fill count, queue and output; no clearing pass.
//  Front and back stall independently through the group queue.
// ============================================================================
module base64_stream_encoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_code_char,
   output logic       rsp_final_char
);

   b64enc_pkg::group_type grp_data, q_data;
   logic                  grp_push, q_full, q_empty, q_pop;

   b64enc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .q_full             (q_full),
      .grp_push           (grp_push),
      .grp_data           (grp_data)
   );

   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   b64enc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_code_char  (rsp_code_char),
      .rsp_final_char (rsp_final_char)
   );

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(grp_push && q_full))
      else $error("group pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("group popped from empty queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response present after reset");

   a_final_pad: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_final_char) |->
         (rsp_code_char != 8'h00 && rsp_code_char != 8'h20))
      else $error("final character not a valid code");
`endif

endmodule

// ===== src/b64enc_front.sv =====
// ============================================================================
// b64enc_front
// Gathers request bytes into groups of three and closes a group when it is
// complete or the message ends.
// ============================================================================
module b64enc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_end_of_message,
   input  logic                       q_full,
   output logic                       grp_push,
   output b64enc_pkg::group_type      grp_data
);

   logic [b64enc_pkg::FILL_W-1:0] fill_ff, fill_in, fill;
   logic [15:0]                   pending_ff, pending_in;
   logic                          accept, close;
   logic [7:0]                    b0, b1, b2;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign fill     = (fill_ff > b64enc_pkg::FILL_TWO) ? b64enc_pkg::FILL_TWO : fill_ff;
   assign close    = (fill == b64enc_pkg::FILL_TWO) || req_end_of_message;
   assign grp_push = accept && close;

   always_comb begin
      b0 = (fill == b64enc_pkg::FILL_NONE) ? req_data_byte : pending_ff[15:8];
      b1 = (fill == b64enc_pkg::FILL_NONE) ? 8'h00 :
           (fill == b64enc_pkg::FILL_ONE)  ? req_data_byte : pending_ff[7:0];
      b2 = (fill == b64enc_pkg::FILL_TWO)  ? req_data_byte : 8'h00;
      grp_data.word       = {b0, b1, b2};
      grp_data.data_count = {1'b0, fill} + 3'd2;
      grp_data.last       = req_end_of_message;
   end

   always_comb begin
      fill_in    = fill_ff;
      pending_in = pending_ff;
      if (accept) begin
         if (close) begin
            fill_in    = b64enc_pkg::FILL_NONE;
            pending_in = '0;
         end else begin
            fill_in    = fill + 2'd1;
            pending_in = (fill == b64enc_pkg::FILL_NONE) ? {req_data_byte, 8'h00}
                                                         : {pending_ff[15:8], req_data_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= b64enc_pkg::FILL_NONE;
         pending_ff <= '0;
      end else begin
         fill_ff    <= fill_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== src/b64enc_queue.sv =====
// ============================================================================
// b64enc_queue
// Short queue of closed groups between the front and back parts.
// ============================================================================
module b64enc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64enc_pkg::group_type push_data,
   output logic                  full,
   input  logic                  pop,
   output b64enc_pkg::group_type pop_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   b64enc_pkg::group_type slots_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/b64enc_back.sv =====
// ============================================================================
// b64enc_back
// Takes closed groups and emits four characters each into an output register,
// one per cycle while that register is empty or being popped.
// ============================================================================
module b64enc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  b64enc_pkg::group_type q_data,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_code_char,
   output logic                  rsp_final_char
);

   b64enc_pkg::group_type grp_ff, grp_in;
   logic                  busy_ff, busy_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            char_ff, char_in;
   logic                  final_ff, final_in;
   logic                  advance, done;
   logic [5:0]            sextet;

   assign advance = busy_ff && (!out_valid_ff || rsp_pop);
   assign done    = advance && (idx_ff == 2'd3);
   assign q_pop   = !q_empty && (!busy_ff || done);

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = grp_ff.word[23:18];
         2'd1:    sextet = grp_ff.word[17:12];
         2'd2:    sextet = grp_ff.word[11:6];
         2'd3:    sextet = grp_ff.word[5:0];
         default: sextet = '0;
      endcase
   end

   always_comb begin
      grp_in       = grp_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      final_in     = final_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         char_in      = ({1'b0, idx_ff} < grp_ff.data_count)
                        ? b64enc_pkg::sextet_char(sextet) : b64enc_pkg::PAD_CHAR;
         final_in     = grp_ff.last && (idx_ff == 2'd3);
         idx_in       = idx_ff + 2'd1;
         if (done) begin
            busy_in = 1'b0;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (q_pop) begin
         grp_in  = q_data;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff   <= grp_in;
      char_ff  <= char_in;
      final_ff <= final_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_code_char  = char_ff;
   assign rsp_final_char = final_ff;

endmodule
